// File: sv/bfba_pkg.sv
package bfba_pkg;

    localparam int SECTOR_BYTES   = 512;
    localparam int BITMAP_SECTORS = 1;
    localparam int BITS_PER_BYTE  = 8;

    // bytes in the usage map, and how many of them a find may look at
    // (only blocks 0..4095 fit the index field)
    localparam int MAP_BYTES   = BITMAP_SECTORS * SECTOR_BYTES;
    localparam int INDEX_W     = 12;
    localparam int INDEX_BYTES = (1 << INDEX_W) / BITS_PER_BYTE;
    localparam int SCAN_BYTES  = (MAP_BYTES < INDEX_BYTES) ? MAP_BYTES : INDEX_BYTES;
    localparam int ADDR_W      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int KIND_W      = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_FIND  = 2'd1,
        KIND_MARK  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        RES_DONE = 2'd0,
        RES_HIT  = 2'd1,
        RES_MARK = 2'd2,
        RES_NONE = 2'd3
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     addr_inc;
        logic     rd_en;
        logic     wr_en;
        logic     wr_mark;
        logic     sel_mark;
        logic     chk_cap;
        logic     res_set;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic map_last;
        logic scan_last;
        logic hit;
        logic mark_in_range;
        logic out_free;
    } t_dp_stat;

endpackage

// File: sv/bfba_ctrl.sv
module bfba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_kind,
    output logic               o_ready,
    input  bfba_pkg::t_dp_stat i_stat,
    output bfba_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_FIND0,
        S_FIND,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                // clearing pass after reset
                o_cmd.wr_en    = 1'b1;
                o_cmd.addr_inc = 1'b1;
                if (i_stat.map_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_kind)
                        bfba_pkg::KIND_CLEAR: n_state = S_CLEAR;
                        bfba_pkg::KIND_FIND:  n_state = S_FIND0;
                        bfba_pkg::KIND_MARK:  n_state = S_MARK_RD;
                        default: begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_sel = bfba_pkg::RES_NONE;
                            n_state       = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.addr_inc = 1'b1;
                if (i_stat.map_last) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = bfba_pkg::RES_DONE;
                    n_state       = S_DONE;
                end
            end
            S_FIND0: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_inc = 1'b1;
                o_cmd.chk_cap  = 1'b1;
                n_state        = S_FIND;
            end
            S_FIND: begin
                if (i_stat.hit) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = bfba_pkg::RES_HIT;
                    n_state       = S_DONE;
                end else if (i_stat.scan_last) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = bfba_pkg::RES_NONE;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_inc = 1'b1;
                    o_cmd.chk_cap  = 1'b1;
                end
            end
            S_MARK_RD: begin
                if (i_stat.mark_in_range) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.sel_mark = 1'b1;
                    n_state        = S_MARK_WR;
                end else begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = bfba_pkg::RES_MARK;
                    n_state       = S_DONE;
                end
            end
            S_MARK_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_mark  = 1'b1;
                o_cmd.sel_mark = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_sel  = bfba_pkg::RES_MARK;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

// File: sv/bfba_dp.sv
module bfba_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfba_pkg::t_dp_cmd             i_cmd,
    output bfba_pkg::t_dp_stat            o_stat,
    input  logic [bfba_pkg::INDEX_W-1:0]  i_block_index,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [bfba_pkg::INDEX_W-1:0]  o_free_index
);

    localparam int FULL_W = bfba_pkg::ADDR_W + 3;

    logic [7:0] r_mem [bfba_pkg::MAP_BYTES];

    logic [bfba_pkg::ADDR_W-1:0]  r_addr;
    logic [bfba_pkg::ADDR_W-1:0]  r_chk_addr;
    logic [7:0]                   r_rd_data;
    logic [bfba_pkg::INDEX_W-1:0] r_index;
    logic                         r_res_found;
    logic [bfba_pkg::INDEX_W-1:0] r_res_index;
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [bfba_pkg::INDEX_W-1:0] r_out_index;

    logic [bfba_pkg::ADDR_W-1:0]  mark_addr;
    logic [bfba_pkg::ADDR_W-1:0]  mem_addr;
    logic [7:0]                   wr_data;
    logic [7:0]                   mark_bit;
    logic [2:0]                   first_zero;
    logic [FULL_W-1:0]            hit_full;
    logic [31:0]                  hit_wide;

    // lowest clear bit of a byte, LSB first
    function automatic logic [2:0] lowest_zero(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (!b[k]) begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

    assign mark_addr  = bfba_pkg::ADDR_W'(32'(r_index[bfba_pkg::INDEX_W-1:3]));
    assign mem_addr   = i_cmd.sel_mark ? mark_addr : r_addr;
    assign mark_bit   = 8'd1 << r_index[2:0];
    assign wr_data    = i_cmd.wr_mark ? (r_rd_data | mark_bit) : 8'd0;
    assign first_zero = lowest_zero(r_rd_data);
    assign hit_full   = {r_chk_addr, first_zero};
    assign hit_wide   = 32'(hit_full);

    assign o_stat.map_last      = (r_addr == bfba_pkg::ADDR_W'(bfba_pkg::MAP_BYTES - 1));
    assign o_stat.scan_last     = (r_chk_addr == bfba_pkg::ADDR_W'(bfba_pkg::SCAN_BYTES - 1));
    assign o_stat.hit           = (r_rd_data != 8'hFF);
    assign o_stat.mark_in_range = (32'(r_index[bfba_pkg::INDEX_W-1:3]) < bfba_pkg::MAP_BYTES);
    assign o_stat.out_free      = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[mem_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.addr_inc) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_index <= i_block_index;
        end
        if (i_cmd.chk_cap) begin
            r_chk_addr <= r_addr;
        end
        if (i_cmd.res_set) begin
            case (i_cmd.res_sel)
                bfba_pkg::RES_DONE: begin
                    r_res_found <= 1'b1;
                    r_res_index <= '0;
                end
                bfba_pkg::RES_HIT: begin
                    r_res_found <= 1'b1;
                    r_res_index <= hit_wide[bfba_pkg::INDEX_W-1:0];
                end
                bfba_pkg::RES_MARK: begin
                    r_res_found <= o_stat.mark_in_range;
                    r_res_index <= r_index;
                end
                default: begin
                    r_res_found <= 1'b0;
                    r_res_index <= '0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_index <= r_res_index;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_free_index = r_out_index;

endmodule

// File: sv/bitmap_free_block_allocator_unit.sv
// Channel  Direction  Handshake           Payload
// request  in         i_valid / o_ready   i_kind[1:0], i_block_index[11:0]
// result   out        o_valid / i_ready   o_found, o_free_index[11:0]
//
// One item at a time. Clear writes one map byte per cycle, find reads one
// byte per cycle through the single map RAM port, stopping at the first byte
// with a free bit, mark reads, then writes back the byte, and unused kinds go
// straight to a result with o_found low. After reset a clearing pass over all
// MAP_BYTES map bytes (512 by default) zeroes the map with o_ready low. A
// finished result waits in the output register; the next item is taken while
// it waits, and only its own completion stalls if the result has not yet been
// taken.
module bitmap_free_block_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bfba_pkg::KIND_W-1:0]  i_kind,
    input  logic [bfba_pkg::INDEX_W-1:0] i_block_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_found,
    output logic [bfba_pkg::INDEX_W-1:0] o_free_index
);

    bfba_pkg::t_dp_cmd  dp_cmd;
    bfba_pkg::t_dp_stat dp_stat;

    // sequencer: owns the item's progress through the map
    bfba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // map RAM, scan address, first-zero encoder, result and output registers
    bfba_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_block_index (i_block_index),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_found       (o_found),
        .o_free_index  (o_free_index)
    );

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while previous item still in progress");

    // a result never appears straight after acceptance
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(i_valid && o_ready))
        else $error("result shown in the cycle after acceptance");

    // a successful clear, find or mark always names a block inside the map
    a_found_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (32'(o_free_index) < bfba_pkg::MAP_BYTES * 8))
        else $error("found block lies outside the map");

endmodule
